### sv/tdsch_pkg.sv
// Shared types and constants for the task dependency scheduler.
package tdsch_pkg;

  localparam int unsigned TASK_SLOTS     = 64;
  localparam int unsigned SLOT_W         = $clog2(TASK_SLOTS);
  localparam int unsigned RUN_QUEUES     = 4;
  localparam int unsigned QUEUE_W        = $clog2(RUN_QUEUES);
  localparam int unsigned MAX_DEPENDENTS = 8;
  localparam int unsigned DEP_IDX_W      = $clog2(MAX_DEPENDENTS);
  localparam int unsigned DCNT_W         = DEP_IDX_W + 1;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned FIFO_CNT_W     = SLOT_W + 1;
  localparam int unsigned REL_W          = 4;

  localparam logic [CNT_W-1:0]      COUNT_MAX = 7'd127;
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(TASK_SLOTS);
  localparam logic [DCNT_W-1:0]     DEP_FULL  = DCNT_W'(MAX_DEPENDENTS);

  typedef enum logic [2:0] {
    KIND_CREATE   = 3'd0,
    KIND_ADD_DEP  = 3'd1,
    KIND_DISPATCH = 3'd2,
    KIND_FETCH    = 3'd3,
    KIND_COMPLETE = 3'd4,
    KIND_REF_ADD  = 3'd5,
    KIND_REF_DROP = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_STATE  = 3'd1,
    STAT_NO_SLOT    = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_NOTHING    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RS_UNALLOC      = 3'd0,
    RS_PEND_DISPATCH = 3'd1,
    RS_PEND_DEPS    = 3'd2,
    RS_PEND_RUN     = 3'd3,
    RS_RUNNING      = 3'd4,
    RS_COMPLETE     = 3'd5
  } run_state_e;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_DECODE, SQ_CR_WR, SQ_GOT_T, SQ_GOT_P, SQ_AD_WR_T,
    SQ_CO_LOOP, SQ_CO_D, SQ_CO_UPD, SQ_CO_FIN, SQ_FE_S, SQ_FE_W, SQ_DONE
  } seq_e;

  typedef struct packed {
    run_state_e          rstate;
    logic [QUEUE_W-1:0]  queue;
    logic [CNT_W-1:0]    outst;
    logic [CNT_W-1:0]    refc;
    logic [DCNT_W-1:0]   dcnt;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

### sv/tdsch_ram.sv
// Generic single-port RAM with registered read data.
module tdsch_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/task_dependency_scheduler_core.sv
// Top level of the task dependency scheduler: command sequencer and task tables.
//
// Usage: drive kind_i, task_req_i, prerequisite_i, queue_id_i and queue_mask_i
// and raise start; the command word is taken at a clock edge with start high
// and busy low. busy then stays high until the result has been shown. The
// result (status_o, slot_o, freed_o, released_count_o) is valid for exactly
// one cycle while done_o is high; the receiver must take it then, it cannot
// hold it off. One command is worked on at a time.
// How long a command takes is set by the single port of the slot record RAM,
// which every read-modify-write goes through, and for complete by the walk
// over its list of up to eight dependents, one entry at a time. A new command
// may be started in the cycle after done_o.
// Reset clears every slot to unallocated through per-slot valid bits, refills
// the free list with slots in ascending order and empties the run queues; no
// clearing pass is needed, so commands are taken straight after reset.
module task_dependency_scheduler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     kind_i,
  input  logic [tdsch_pkg::SLOT_W-1:0]   task_req_i,
  input  logic [tdsch_pkg::SLOT_W-1:0]   prerequisite_i,
  input  logic [tdsch_pkg::QUEUE_W-1:0]  queue_id_i,
  input  logic [tdsch_pkg::RUN_QUEUES-1:0] queue_mask_i,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic [tdsch_pkg::SLOT_W-1:0]   slot_o,
  output logic                           freed_o,
  output logic [tdsch_pkg::REL_W-1:0]    released_count_o
);

  localparam int unsigned SW  = tdsch_pkg::SLOT_W;
  localparam int unsigned QW  = tdsch_pkg::QUEUE_W;
  localparam int unsigned NQ  = tdsch_pkg::RUN_QUEUES;
  localparam int unsigned FCW = tdsch_pkg::FIFO_CNT_W;
  localparam int unsigned NS  = tdsch_pkg::TASK_SLOTS;

  tdsch_pkg::seq_e state_q, state_d;

  logic [2:0]    kind_q, kind_d;
  logic [SW-1:0] t_q, t_d, p_q, p_d, d_q, d_d;
  logic [QW-1:0] qid_q, qid_d, fq_q, fq_d;
  logic [NQ-1:0] mask_q, mask_d;
  tdsch_pkg::rec_t rect_q, rect_d;
  logic [tdsch_pkg::DCNT_W-1:0] idx_q, idx_d, n_q, n_d;
  logic [2:0]    status_q, status_d;
  logic [SW-1:0] slot_q, slot_d;
  logic          freed_q, freed_d;
  logic [tdsch_pkg::REL_W-1:0] rel_q, rel_d;

  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] fw_q, fw_d;
  logic [SW-1:0] fhead_q, fhead_d, ftail_q, ftail_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [SW-1:0]  rhead_q [NQ];
  logic [SW-1:0]  rhead_d [NQ];
  logic [SW-1:0]  rtail_q [NQ];
  logic [SW-1:0]  rtail_d [NQ];
  logic [FCW-1:0] rcnt_q [NQ];
  logic [FCW-1:0] rcnt_d [NQ];
  logic          recv_q;

  // RAM ports
  logic          rec_we;
  logic [SW-1:0] rec_addr;
  tdsch_pkg::rec_t rec_wdata, rec_rdata, rec_rd;
  logic          dep_we;
  logic [SW+tdsch_pkg::DEP_IDX_W-1:0] dep_addr;
  logic [SW-1:0] dep_rdata;
  logic          rdy_we;
  logic [QW+SW-1:0] rdy_addr;
  logic [SW-1:0] rdy_wdata, rdy_rdata;
  logic          free_we;
  logic [SW-1:0] free_addr, free_wdata, free_rdata, free_slot;

  logic          qhit;
  logic [QW-1:0] qsel;
  logic          push_en, fpush_en;
  logic [QW-1:0] push_q;
  logic [SW-1:0] push_s, fpush_s;

  tdsch_ram #(.Width(tdsch_pkg::REC_W), .Depth(NS)) u_rec_ram (
    .clk_i, .we_i(rec_we), .addr_i(rec_addr), .wdata_i(rec_wdata), .rdata_o(rec_rdata)
  );
  tdsch_ram #(.Width(SW), .Depth(NS * tdsch_pkg::MAX_DEPENDENTS)) u_dep_ram (
    .clk_i, .we_i(dep_we), .addr_i(dep_addr), .wdata_i(t_q), .rdata_o(dep_rdata)
  );
  tdsch_ram #(.Width(SW), .Depth(NS * NQ)) u_rdy_ram (
    .clk_i, .we_i(rdy_we), .addr_i(rdy_addr), .wdata_i(rdy_wdata), .rdata_o(rdy_rdata)
  );
  tdsch_ram #(.Width(SW), .Depth(NS)) u_free_ram (
    .clk_i, .we_i(free_we), .addr_i(free_addr), .wdata_i(free_wdata), .rdata_o(free_rdata)
  );

  // A slot that is not valid reads as unallocated with zero counts
  assign rec_rd    = recv_q ? rec_rdata : '0;
  assign free_slot = fw_q[fhead_q] ? free_rdata : fhead_q;

  // Lowest-numbered selected queue that holds work
  always_comb begin
    qhit = 1'b0;
    qsel = '0;
    for (int i = 0; i < NQ; i++) begin
      if (!qhit && mask_q[i] && (rcnt_q[i] != '0)) begin
        qhit = 1'b1;
        qsel = QW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdsch_pkg::SQ_IDLE: begin
        if (start) state_d = tdsch_pkg::SQ_DECODE;
      end
      tdsch_pkg::SQ_DECODE: begin
        unique case (kind_q)
          tdsch_pkg::KIND_CREATE:
            state_d = (fcnt_q == '0) ? tdsch_pkg::SQ_DONE : tdsch_pkg::SQ_CR_WR;
          tdsch_pkg::KIND_FETCH:
            state_d = qhit ? tdsch_pkg::SQ_FE_S : tdsch_pkg::SQ_DONE;
          tdsch_pkg::KIND_ADD_DEP, tdsch_pkg::KIND_DISPATCH, tdsch_pkg::KIND_COMPLETE,
          tdsch_pkg::KIND_REF_ADD, tdsch_pkg::KIND_REF_DROP:
            state_d = tdsch_pkg::SQ_GOT_T;
          default: state_d = tdsch_pkg::SQ_DONE;
        endcase
      end
      tdsch_pkg::SQ_GOT_T: begin
        if (kind_q == tdsch_pkg::KIND_ADD_DEP &&
            rec_rd.rstate == tdsch_pkg::RS_PEND_DISPATCH) begin
          state_d = tdsch_pkg::SQ_GOT_P;
        end else if (kind_q == tdsch_pkg::KIND_COMPLETE &&
                     rec_rd.rstate == tdsch_pkg::RS_RUNNING) begin
          state_d = tdsch_pkg::SQ_CO_LOOP;
        end else begin
          state_d = tdsch_pkg::SQ_DONE;
        end
      end
      tdsch_pkg::SQ_GOT_P: begin
        if (rec_rd.rstate == tdsch_pkg::RS_PEND_DISPATCH &&
            rec_rd.dcnt < tdsch_pkg::DEP_FULL && rect_q.outst < tdsch_pkg::COUNT_MAX &&
            p_q != t_q) begin
          state_d = tdsch_pkg::SQ_AD_WR_T;
        end else begin
          state_d = tdsch_pkg::SQ_DONE;
        end
      end
      tdsch_pkg::SQ_CO_LOOP:
        state_d = (idx_q == n_q) ? tdsch_pkg::SQ_CO_FIN : tdsch_pkg::SQ_CO_D;
      tdsch_pkg::SQ_CO_D:   state_d = tdsch_pkg::SQ_CO_UPD;
      tdsch_pkg::SQ_CO_UPD: state_d = tdsch_pkg::SQ_CO_LOOP;
      tdsch_pkg::SQ_FE_S:   state_d = tdsch_pkg::SQ_FE_W;
      tdsch_pkg::SQ_CR_WR, tdsch_pkg::SQ_AD_WR_T, tdsch_pkg::SQ_CO_FIN,
      tdsch_pkg::SQ_FE_W:   state_d = tdsch_pkg::SQ_DONE;
      tdsch_pkg::SQ_DONE:   state_d = tdsch_pkg::SQ_IDLE;
      default:              state_d = tdsch_pkg::SQ_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    tdsch_pkg::rec_t r;
    kind_d = kind_q; t_d = t_q; p_d = p_q; d_d = d_q; qid_d = qid_q; fq_d = fq_q;
    mask_d = mask_q; rect_d = rect_q; idx_d = idx_q; n_d = n_q;
    status_d = status_q; slot_d = slot_q; freed_d = freed_q; rel_d = rel_q;
    valid_d = valid_q; fw_d = fw_q;
    fhead_d = fhead_q; ftail_d = ftail_q; fcnt_d = fcnt_q;
    rhead_d = rhead_q; rtail_d = rtail_q; rcnt_d = rcnt_q;
    rec_we = 1'b0; rec_addr = t_q; rec_wdata = rec_rd;
    dep_we = 1'b0; dep_addr = {t_q, idx_q[tdsch_pkg::DEP_IDX_W-1:0]};
    rdy_we = 1'b0; rdy_addr = {qsel, rhead_q[qsel]}; rdy_wdata = t_q;
    free_we = 1'b0; free_addr = fhead_q; free_wdata = t_q;
    push_en = 1'b0; push_q = '0; push_s = t_q;
    fpush_en = 1'b0; fpush_s = t_q;
    r = rec_rd;

    unique case (state_q)
      tdsch_pkg::SQ_IDLE: begin
        if (start) begin
          kind_d = kind_i; t_d = task_req_i; p_d = prerequisite_i;
          qid_d = queue_id_i; mask_d = queue_mask_i;
          status_d = tdsch_pkg::STAT_OK; slot_d = '0; freed_d = 1'b0; rel_d = '0;
        end
      end
      tdsch_pkg::SQ_DECODE: begin
        fq_d = qsel;
        unique case (kind_q)
          tdsch_pkg::KIND_CREATE:
            if (fcnt_q == '0) status_d = tdsch_pkg::STAT_NO_SLOT;
          tdsch_pkg::KIND_FETCH:
            if (!qhit) status_d = tdsch_pkg::STAT_NOTHING;
          tdsch_pkg::KIND_ADD_DEP, tdsch_pkg::KIND_DISPATCH, tdsch_pkg::KIND_COMPLETE,
          tdsch_pkg::KIND_REF_ADD, tdsch_pkg::KIND_REF_DROP: ;
          default: status_d = tdsch_pkg::STAT_BAD_STATE;
        endcase
      end
      tdsch_pkg::SQ_CR_WR: begin
        rec_we = 1'b1;
        rec_addr = free_slot;
        rec_wdata = '{rstate: tdsch_pkg::RS_PEND_DISPATCH, queue: qid_q, outst: '0,
                      refc: tdsch_pkg::CNT_W'(1), dcnt: '0};
        valid_d[free_slot] = 1'b1;
        fhead_d = fhead_q + 1'b1;
        fcnt_d = fcnt_q - 1'b1;
        slot_d = free_slot;
      end
      tdsch_pkg::SQ_GOT_T: begin
        rect_d = rec_rd;
        n_d = rec_rd.dcnt;
        idx_d = '0;
        unique case (kind_q)
          tdsch_pkg::KIND_ADD_DEP: begin
            rec_addr = p_q;
            if (rec_rd.rstate != tdsch_pkg::RS_PEND_DISPATCH)
              status_d = tdsch_pkg::STAT_BAD_STATE;
          end
          tdsch_pkg::KIND_DISPATCH: begin
            if (rec_rd.rstate == tdsch_pkg::RS_PEND_DISPATCH ||
                rec_rd.rstate == tdsch_pkg::RS_PEND_DEPS) begin
              rec_we = 1'b1;
              if (rec_rd.outst != '0) begin
                r.rstate = tdsch_pkg::RS_PEND_DEPS;
              end else begin
                r.rstate = tdsch_pkg::RS_PEND_RUN;
                push_en = 1'b1; push_q = rec_rd.queue; push_s = t_q;
              end
              rec_wdata = r;
            end else begin
              status_d = tdsch_pkg::STAT_BAD_STATE;
            end
          end
          tdsch_pkg::KIND_COMPLETE: begin
            if (rec_rd.rstate != tdsch_pkg::RS_RUNNING) status_d = tdsch_pkg::STAT_BAD_STATE;
          end
          tdsch_pkg::KIND_REF_ADD: begin
            if (rec_rd.rstate == tdsch_pkg::RS_UNALLOC) begin
              status_d = tdsch_pkg::STAT_BAD_STATE;
            end else if (rec_rd.refc >= tdsch_pkg::COUNT_MAX) begin
              status_d = tdsch_pkg::STAT_FULL;
            end else begin
              r.refc = rec_rd.refc + 1'b1;
              rec_we = 1'b1; rec_wdata = r;
            end
          end
          tdsch_pkg::KIND_REF_DROP: begin
            if (rec_rd.rstate == tdsch_pkg::RS_UNALLOC || rec_rd.refc == '0) begin
              status_d = tdsch_pkg::STAT_BAD_STATE;
            end else begin
              r.refc = rec_rd.refc - 1'b1;
              if (r.refc == '0 && rec_rd.rstate == tdsch_pkg::RS_COMPLETE) begin
                fpush_en = 1'b1; fpush_s = t_q; freed_d = 1'b1;
              end else begin
                rec_we = 1'b1; rec_wdata = r;
              end
            end
          end
          default: ;
        endcase
      end
      tdsch_pkg::SQ_GOT_P: begin
        rec_addr = p_q;
        if (rec_rd.rstate != tdsch_pkg::RS_PEND_DISPATCH) begin
          status_d = tdsch_pkg::STAT_BAD_STATE;
        end else if (rec_rd.dcnt >= tdsch_pkg::DEP_FULL ||
                     rect_q.outst >= tdsch_pkg::COUNT_MAX) begin
          status_d = tdsch_pkg::STAT_FULL;
        end else begin
          dep_we = 1'b1;
          dep_addr = {p_q, rec_rd.dcnt[tdsch_pkg::DEP_IDX_W-1:0]};
          r.dcnt = rec_rd.dcnt + 1'b1;
          // self dependency: both counts live in the same record
          if (p_q == t_q) r.outst = rec_rd.outst + 1'b1;
          rec_we = 1'b1; rec_wdata = r;
        end
      end
      tdsch_pkg::SQ_AD_WR_T: begin
        r = rect_q;
        r.outst = rect_q.outst + 1'b1;
        rec_we = 1'b1; rec_wdata = r;
      end
      tdsch_pkg::SQ_CO_LOOP: ;
      tdsch_pkg::SQ_CO_D: begin
        d_d = dep_rdata;
        rec_addr = dep_rdata;
      end
      tdsch_pkg::SQ_CO_UPD: begin
        rec_addr = d_q;
        idx_d = idx_q + 1'b1;
        if (rec_rd.outst != '0) begin
          r.outst = rec_rd.outst - 1'b1;
          if (r.outst == '0 && rec_rd.rstate == tdsch_pkg::RS_PEND_DEPS) begin
            r.rstate = tdsch_pkg::RS_PEND_RUN;
            push_en = 1'b1; push_q = rec_rd.queue; push_s = d_q;
            rel_d = rel_q + 1'b1;
          end
          rec_we = 1'b1; rec_wdata = r;
        end
      end
      tdsch_pkg::SQ_CO_FIN: begin
        if (rec_rd.refc == '0) begin
          fpush_en = 1'b1; fpush_s = t_q; freed_d = 1'b1;
        end else begin
          r.rstate = tdsch_pkg::RS_COMPLETE;
          rec_we = 1'b1; rec_wdata = r;
        end
      end
      tdsch_pkg::SQ_FE_S: begin
        rhead_d[fq_q] = rhead_q[fq_q] + 1'b1;
        rcnt_d[fq_q] = rcnt_q[fq_q] - 1'b1;
        slot_d = rdy_rdata;
        d_d = rdy_rdata;
        rec_addr = rdy_rdata;
      end
      tdsch_pkg::SQ_FE_W: begin
        rec_addr = d_q;
        r.rstate = tdsch_pkg::RS_RUNNING;
        rec_we = 1'b1; rec_wdata = r;
      end
      tdsch_pkg::SQ_DONE: ;
      default: ;
    endcase

    // Append to a run queue
    if (push_en && rcnt_q[push_q] != tdsch_pkg::FIFO_FULL) begin
      rdy_we = 1'b1;
      rdy_addr = {push_q, rtail_q[push_q]};
      rdy_wdata = push_s;
      rtail_d[push_q] = rtail_q[push_q] + 1'b1;
      rcnt_d[push_q] = rcnt_q[push_q] + 1'b1;
    end

    // Return a slot to the free list; dropping the valid bit marks it unallocated
    if (fpush_en) begin
      valid_d[fpush_s] = 1'b0;
      if (fcnt_q != tdsch_pkg::FIFO_FULL) begin
        free_we = 1'b1;
        free_addr = ftail_q;
        free_wdata = fpush_s;
        fw_d[ftail_q] = 1'b1;
        ftail_d = ftail_q + 1'b1;
        fcnt_d = fcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdsch_pkg::SQ_IDLE;
      valid_q <= '0;
      fw_q    <= '0;
      fhead_q <= '0;
      ftail_q <= '0;
      fcnt_q  <= tdsch_pkg::FIFO_FULL;
      for (int i = 0; i < NQ; i++) begin
        rhead_q[i] <= '0;
        rtail_q[i] <= '0;
        rcnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      fw_q    <= fw_d;
      fhead_q <= fhead_d;
      ftail_q <= ftail_d;
      fcnt_q  <= fcnt_d;
      rhead_q <= rhead_d;
      rtail_q <= rtail_d;
      rcnt_q  <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; t_q <= t_d; p_q <= p_d; d_q <= d_d;
    qid_q <= qid_d; fq_q <= fq_d; mask_q <= mask_d; rect_q <= rect_d;
    idx_q <= idx_d; n_q <= n_d;
    status_q <= status_d; slot_q <= slot_d; freed_q <= freed_d; rel_q <= rel_d;
    recv_q <= valid_d[rec_addr] & valid_q[rec_addr];
  end

  assign busy             = (state_q != tdsch_pkg::SQ_IDLE);
  assign done_o           = (state_q == tdsch_pkg::SQ_DONE);
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign freed_o          = freed_q;
  assign released_count_o = rel_q;

endmodule

### bench/task_dependency_scheduler_core_tb.sv
// Self-checking bench for the task dependency scheduler: queued commands, golden table model.
module task_dependency_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int NQ = 4;
  localparam int NDEP = 8;
  localparam int CNT_MAX = int'(tdsch_pkg::COUNT_MAX);
  localparam int STALL_LIMIT = 5000;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] tsk;
    logic [5:0] prq;
    logic [1:0] qid;
    logic [3:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic       freed;
    logic [3:0] released;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] kind_i = '0;
  logic [5:0] task_req_i = '0;
  logic [5:0] prerequisite_i = '0;
  logic [1:0] queue_id_i = '0;
  logic [3:0] queue_mask_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [5:0] slot_o;
  logic freed_o;
  logic [3:0] released_count_o;

  task_dependency_scheduler_core dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // Golden copy of the task tables
  tdsch_pkg::run_state_e st[NSLOT];
  logic [1:0] tq[NSLOT];
  int outst[NSLOT], refc[NSLOT], dcnt[NSLOT];
  int deps[NSLOT][NDEP];
  int free_q[$];
  int ready_q[NQ][$];

  cmd_t  pending_cmds[$];
  resp_t expected_resps[$];
  int errors = 0;
  int quiet_cycles = 0;
  int sent = 0;
  bit taken = 1'b0;
  bit feeding_done = 1'b0;

  function automatic void sched_reset();
    free_q.delete();
    for (int i = 0; i < NSLOT; i++) begin
      st[i] = tdsch_pkg::RS_UNALLOC; tq[i] = '0; outst[i] = 0; refc[i] = 0; dcnt[i] = 0;
      free_q = {free_q, i};
    end
    for (int q = 0; q < NQ; q++) ready_q[q].delete();
  endfunction

  function automatic void make_ready(int s);
    st[s] = tdsch_pkg::RS_PEND_RUN;
    ready_q[tq[s]] = {ready_q[tq[s]], s};
  endfunction

  function automatic resp_t sched_step(cmd_t c);
    resp_t r;
    int t, p, d;
    r = '0;
    t = int'(c.tsk); p = int'(c.prq);
    case (c.kind)
      tdsch_pkg::KIND_CREATE: begin
        if (free_q.size() == 0) r.status = tdsch_pkg::STAT_NO_SLOT;
        else begin
          d = free_q.pop_front();
          st[d] = tdsch_pkg::RS_PEND_DISPATCH; tq[d] = c.qid;
          outst[d] = 0; refc[d] = 1; dcnt[d] = 0;
          r.slot = 6'(d);
        end
      end
      tdsch_pkg::KIND_ADD_DEP: begin
        if (st[t] != tdsch_pkg::RS_PEND_DISPATCH || st[p] != tdsch_pkg::RS_PEND_DISPATCH)
          r.status = tdsch_pkg::STAT_BAD_STATE;
        else if (dcnt[p] >= NDEP || outst[t] >= CNT_MAX) r.status = tdsch_pkg::STAT_FULL;
        else begin
          deps[p][dcnt[p]] = t; dcnt[p]++; outst[t]++;
        end
      end
      tdsch_pkg::KIND_DISPATCH: begin
        if (st[t] != tdsch_pkg::RS_PEND_DISPATCH && st[t] != tdsch_pkg::RS_PEND_DEPS)
          r.status = tdsch_pkg::STAT_BAD_STATE;
        else if (outst[t] > 0) st[t] = tdsch_pkg::RS_PEND_DEPS;
        else make_ready(t);
      end
      tdsch_pkg::KIND_FETCH: begin
        r.status = tdsch_pkg::STAT_NOTHING;
        for (int q = 0; q < NQ; q++)
          if (r.status == tdsch_pkg::STAT_NOTHING && c.mask[q] && ready_q[q].size() > 0) begin
            d = ready_q[q].pop_front();
            st[d] = tdsch_pkg::RS_RUNNING; r.slot = 6'(d); r.status = tdsch_pkg::STAT_OK;
          end
      end
      tdsch_pkg::KIND_COMPLETE: begin
        if (st[t] != tdsch_pkg::RS_RUNNING) r.status = tdsch_pkg::STAT_BAD_STATE;
        else begin
          for (int i = 0; i < dcnt[t]; i++) begin
            d = deps[t][i];
            if (outst[d] > 0) begin
              outst[d]--;
              if (outst[d] == 0 && st[d] == tdsch_pkg::RS_PEND_DEPS) begin
                make_ready(d); r.released = r.released + 4'd1;
              end
            end
          end
          st[t] = tdsch_pkg::RS_COMPLETE;
          if (refc[t] == 0) begin
            st[t] = tdsch_pkg::RS_UNALLOC; free_q = {free_q, t}; r.freed = 1'b1;
          end
        end
      end
      tdsch_pkg::KIND_REF_ADD: begin
        if (st[t] == tdsch_pkg::RS_UNALLOC) r.status = tdsch_pkg::STAT_BAD_STATE;
        else if (refc[t] >= CNT_MAX) r.status = tdsch_pkg::STAT_FULL;
        else refc[t]++;
      end
      tdsch_pkg::KIND_REF_DROP: begin
        if (st[t] == tdsch_pkg::RS_UNALLOC || refc[t] == 0) r.status = tdsch_pkg::STAT_BAD_STATE;
        else begin
          refc[t]--;
          if (refc[t] == 0 && st[t] == tdsch_pkg::RS_COMPLETE) begin
            st[t] = tdsch_pkg::RS_UNALLOC; free_q = {free_q, t}; r.freed = 1'b1;
          end
        end
      end
      default: r.status = tdsch_pkg::STAT_BAD_STATE;
    endcase
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] k, int t, int p, int q, int m);
    cmd_t c;
    c.kind = k; c.tsk = 6'(t); c.prq = 6'(p); c.qid = 2'(q); c.mask = 4'(m);
    return c;
  endfunction

  function automatic cmd_t rnd_cmd(logic [2:0] k);
    return mk(k, $urandom_range(63), $urandom_range(63), $urandom_range(3), $urandom_range(15));
  endfunction

  function automatic void queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  // Driver: present the next word at the falling edge, drop start once taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((!start || taken) && pending_cmds.size() > 0 &&
          ((sent >= 300 && sent < 900) || $urandom_range(99) >= 19)) begin
        cmd_t c;
        resp_t e;
        c = pending_cmds.pop_front();
        e = sched_step(c);
        expected_resps = {expected_resps, e};
        kind_i <= c.kind; task_req_i <= c.tsk; prerequisite_i <= c.prq;
        queue_id_i <= c.qid; queue_mask_i <= c.mask;
        start <= 1'b1;
        sent <= sent + 1;
      end else if (taken) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample at the rising edge
  always @(posedge clk_i) begin
    taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        if (expected_resps.size() == 0) begin
          $error("result with no command outstanding");
          errors++;
        end else begin
          resp_t e;
          e = expected_resps.pop_front();
          if (status_o !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status_o); errors++;
          end
          if (slot_o !== e.slot) begin
            $error("slot expected %0d actual %0d", e.slot, slot_o); errors++;
          end
          if (freed_o !== e.freed) begin
            $error("freed expected %0d actual %0d", e.freed, freed_o); errors++;
          end
          if (released_count_o !== e.released) begin
            $error("released_count expected %0d actual %0d", e.released,
                   released_count_o);
            errors++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n, k, r;
    sched_reset();
    // Directed: extremes, every kind, misuse cases
    queue_cmd(mk(tdsch_pkg::KIND_REF_ADD, 63, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_REF_DROP, 0, 0, 0, 0));
    queue_cmd(mk(KIND_UNKNOWN, 5, 5, 3, 15));
    queue_cmd(mk(tdsch_pkg::KIND_FETCH, 0, 0, 0, 15));
    queue_cmd(mk(tdsch_pkg::KIND_CREATE, 0, 0, 3, 0));
    queue_cmd(mk(tdsch_pkg::KIND_CREATE, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_CREATE, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_ADD_DEP, 1, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_ADD_DEP, 2, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_ADD_DEP, 2, 2, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_ADD_DEP, 63, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_DISPATCH, 1, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_DISPATCH, 2, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_DISPATCH, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_COMPLETE, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_FETCH, 0, 0, 0, 7));
    queue_cmd(mk(tdsch_pkg::KIND_FETCH, 0, 0, 0, 8));
    queue_cmd(mk(tdsch_pkg::KIND_REF_DROP, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_COMPLETE, 0, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_FETCH, 0, 0, 0, 1));
    queue_cmd(mk(tdsch_pkg::KIND_COMPLETE, 1, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_REF_DROP, 1, 0, 0, 0));
    queue_cmd(mk(tdsch_pkg::KIND_REF_DROP, 1, 0, 0, 0));
    // Random: mostly well-formed lifecycles over tasks likely to exist
    n = 0;
    while (n < 1950) begin
      r = $urandom_range(99);
      if (r < 18) begin
        // burst of creates, sometimes draining the free list
        k = ($urandom_range(9) == 0) ? 70 : $urandom_range(1, 6);
        for (int i = 0; i < k; i++) queue_cmd(rnd_cmd(tdsch_pkg::KIND_CREATE));
        n += k;
      end else if (r < 93) begin
        cmd_t c;
        k = $urandom_range(1, 6);
        c = rnd_cmd(k[2:0]);
        // bias slot numbers toward the low, busiest slots
        if ($urandom_range(3) != 0) c.tsk = 6'($urandom_range(15));
        if ($urandom_range(3) != 0) c.prq = 6'($urandom_range(15));
        queue_cmd(c);
        n++;
      end else if (r < 97) begin
        // ref_add storm to reach the saturation point
        k = $urandom_range(10, 140);
        for (int i = 0; i < k; i++) queue_cmd(mk(tdsch_pkg::KIND_REF_ADD, 3, 0, 0, 0));
        n += k;
      end else begin
        queue_cmd(mk(KIND_UNKNOWN, $urandom_range(63), $urandom_range(63),
                     $urandom_range(3), $urandom_range(15)));
        n++;
      end
    end
    feeding_done = 1'b1;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    while (!feeding_done || pending_cmds.size() != 0 || start ||
           expected_resps.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### task_dependency_scheduler_core.f
sv/tdsch_pkg.sv
sv/tdsch_ram.sv
sv/task_dependency_scheduler_core.sv
bench/task_dependency_scheduler_core_tb.sv
